/* sv/c8x_pkg.sv */
// shared types and constants of the chip8 instruction executor
package c8x_pkg;

   typedef enum logic [1:0] {
      SEL_EXEC  = 2'd0,
      SEL_WRITE = 2'd1,
      SEL_READ  = 2'd2,
      SEL_PIXEL = 2'd3
   } sel_type;

   typedef enum logic [2:0] {
      K_SIMPLE, K_CLS, K_RET, K_DRAW, K_BCD, K_STORE, K_LOAD
   } kind_type;

   typedef enum logic [3:0] {
      U_NOP, U_INIT, U_LOAD, U_RDX, U_RDY, U_ACC, U_EXEC, U_CLR,
      U_RET, U_DRD, U_DWR, U_BCD, U_STORE, U_LRD, U_LWR, U_DONE
   } uop_type;

   typedef struct packed {
      uop_type uop;
   } cmd_type;

   typedef struct packed {
      logic     init_done;
      sel_type  sel;
      kind_type kind;
      logic     empty;
      logic     last;
   } stat_type;

   localparam logic [11:0] PC_RESET = 12'h200;
   localparam int FRAME_COLS = 64;
   localparam int FRAME_ROWS = 32;
   localparam int COL_BITS = $clog2(FRAME_COLS);
   localparam int ROW_BITS = $clog2(FRAME_ROWS);
   localparam int FONT_BYTES = 80;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

endpackage

/* sv/c8x_ram.sv */
// generic simple dual port ram with registered read
module c8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

/* sv/c8x_ctrl.sv */
// controller state machine of the chip8 instruction executor
module c8x_ctrl import c8x_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy
);

   typedef enum logic [14:0] {
      ST_INIT  = 15'b000000000000001,
      ST_IDLE  = 15'b000000000000010,
      ST_RDX   = 15'b000000000000100,
      ST_RDY   = 15'b000000000001000,
      ST_ACC   = 15'b000000000010000,
      ST_EXEC  = 15'b000000000100000,
      ST_CLR   = 15'b000000001000000,
      ST_RET   = 15'b000000010000000,
      ST_DRD   = 15'b000000100000000,
      ST_DWR   = 15'b000001000000000,
      ST_BCD   = 15'b000010000000000,
      ST_STORE = 15'b000100000000000,
      ST_LRD   = 15'b001000000000000,
      ST_LWR   = 15'b010000000000000,
      ST_DONE  = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.uop  = U_NOP;
      unique case (state_ff)
         ST_INIT: begin
            cmd.uop = U_INIT;
            if (stat.init_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.uop  = U_LOAD;
               state_in = ST_RDX;
            end
         end
         ST_RDX: begin
            cmd.uop  = U_RDX;
            state_in = (stat.sel == SEL_EXEC) ? ST_RDY : ST_ACC;
         end
         ST_RDY: begin
            cmd.uop  = U_RDY;
            state_in = ST_EXEC;
         end
         ST_ACC: begin
            cmd.uop  = U_ACC;
            state_in = ST_DONE;
         end
         ST_EXEC: begin
            cmd.uop = U_EXEC;
            unique case (stat.kind)
               K_CLS:   state_in = ST_CLR;
               K_RET:   state_in = ST_RET;
               K_DRAW:  state_in = stat.empty ? ST_DONE : ST_DRD;
               K_BCD:   state_in = ST_BCD;
               K_STORE: state_in = ST_STORE;
               K_LOAD:  state_in = ST_LRD;
               default: state_in = ST_DONE;
            endcase
         end
         ST_CLR: begin
            cmd.uop = U_CLR;
            if (stat.last) state_in = ST_DONE;
         end
         ST_RET: begin
            cmd.uop  = U_RET;
            state_in = ST_DONE;
         end
         ST_DRD: begin
            cmd.uop  = U_DRD;
            state_in = ST_DWR;
         end
         ST_DWR: begin
            cmd.uop  = U_DWR;
            state_in = stat.last ? ST_DONE : ST_DRD;
         end
         ST_BCD: begin
            cmd.uop = U_BCD;
            if (stat.last) state_in = ST_DONE;
         end
         ST_STORE: begin
            cmd.uop = U_STORE;
            if (stat.last) state_in = ST_DONE;
         end
         ST_LRD: begin
            cmd.uop  = U_LRD;
            state_in = ST_LWR;
         end
         ST_LWR: begin
            cmd.uop  = U_LWR;
            state_in = stat.last ? ST_DONE : ST_LRD;
         end
         ST_DONE: begin
            cmd.uop  = U_DONE;
            state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* sv/c8x_dp.sv */
// datapath of the chip8 instruction executor: registers, memories, alu
module c8x_dp import c8x_pkg::*; #(
   parameter int MEM_BYTES   = 4096,
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_instruction,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_keys_down,
   input  logic [3:0]  req_pressed_key,
   input  logic [7:0]  req_random_byte,
   output stat_type    stat,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [11:0] rsp_next_pc,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_draw_flag,
   output logic [7:0]  rsp_sound_level
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam int SW = $clog2(STACK_DEPTH);

   localparam logic [3:0] G_SYS = 4'h0, G_JP = 4'h1, G_CALL = 4'h2, G_SE = 4'h3;
   localparam logic [3:0] G_SNE = 4'h4, G_SER = 4'h5, G_LD = 4'h6, G_ADD = 4'h7;
   localparam logic [3:0] G_ALU = 4'h8, G_SNER = 4'h9, G_LDI = 4'hA, G_JPV = 4'hB;
   localparam logic [3:0] G_RND = 4'hC, G_DRW = 4'hD, G_KEY = 4'hE, G_MISC = 4'hF;
   localparam logic [3:0] A_MOV = 4'h0, A_OR = 4'h1, A_AND = 4'h2, A_XOR = 4'h3;
   localparam logic [3:0] A_ADD = 4'h4, A_SUB = 4'h5, A_SHR = 4'h6, A_SUBN = 4'h7;
   localparam logic [3:0] A_SHL = 4'hE;
   localparam logic [7:0] S_CLS = 8'hE0, S_RET = 8'hEE;
   localparam logic [7:0] E_SKP = 8'h9E, E_SKNP = 8'hA1;
   localparam logic [7:0] F_GDT = 8'h07, F_KEY = 8'h0A, F_SDT = 8'h15, F_SST = 8'h18;
   localparam logic [7:0] F_ADDI = 8'h1E, F_FONT = 8'h29, F_BCD = 8'h33;
   localparam logic [7:0] F_STR = 8'h55, F_LDR = 8'h65;
   localparam logic [3:0] FLAG_REG = 4'hF;
   localparam logic [7:0] DEC_100 = 8'd100, DEC_200 = 8'd200, RECIP_10 = 8'd205;

   logic [1:0]  sel_ff, sel_in;
   logic [15:0] ins_ff, ins_in;
   logic [11:0] addr_ff, addr_in;
   logic [7:0]  wdat_ff, wdat_in;
   logic [15:0] keys_ff, keys_in;
   logic [3:0]  pkey_ff, pkey_in;
   logic [7:0]  rnd_ff, rnd_in;
   logic [7:0]  vx_ff, vx_in, vy_ff, vy_in;
   logic [7:0]  gp_ff [16];
   logic [7:0]  gp_in [16];
   logic [15:0] i_ff, i_in;
   logic [11:0] pc_ff, pc_in;
   logic [SW-1:0] sp_ff, sp_in;
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [ROW_BITS-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] ic_ff, ic_in;
   logic        bad_ff, bad_in, drew_ff, drew_in;
   logic        rv_ff, rv_in, rstat_ff, rstat_in, rdraw_ff, rdraw_in;
   logic [11:0] rpc_ff, rpc_in;
   logic [7:0]  rdat_ff, rdat_in, rsnd_ff, rsnd_in;

   logic          m_we;
   logic [AW-1:0] m_waddr, m_raddr;
   logic [7:0]    m_wdata, m_rdata;
   logic          f_we;
   logic [ROW_BITS-1:0]   f_waddr, f_raddr;
   logic [FRAME_COLS-1:0] f_wdata, f_rdata;
   logic          s_we;
   logic [SW-1:0] s_raddr;
   logic [11:0]   s_rdata;

   logic [3:0]  grp, x, y, n, vaddr;
   logic [7:0]  nn, vrd;
   logic [11:0] nnn, pc2, pc4;
   logic        held, flag, alu_ok, alu_fl, hit;
   logic [7:0]  ax, ay, alu_res;
   logic [8:0]  sum9;
   logic [1:0]  hund;
   logic [7:0]  rem8, tens10, ones, digit;
   logic [14:0] tprod;
   logic [3:0]  tens;
   logic [FRAME_COLS-1:0] dmask;
   logic [ROW_BITS-1:0]   drow;
   kind_type    kind;

   assign grp = ins_ff[15:12];
   assign x   = ins_ff[11:8];
   assign y   = ins_ff[7:4];
   assign n   = ins_ff[3:0];
   assign nn  = ins_ff[7:0];
   assign nnn = ins_ff[11:0];
   assign pc2 = pc_ff + 12'd2;
   assign pc4 = pc_ff + 12'd4;
   assign held = (vx_ff[7:4] == 4'd0) && keys_ff[vx_ff[3:0]];
   assign drow = vy_ff[ROW_BITS-1:0] + cnt_ff;
   assign hit  = |(f_rdata & dmask);
   assign s_raddr = sp_ff - SW'(1);

   always_comb begin
      vaddr = x;
      if (cmd.uop == U_RDY) begin
         vaddr = (grp == G_JPV) ? 4'd0 : y;
      end else if (cmd.uop == U_STORE) begin
         vaddr = cnt_ff[3:0];
      end
   end
   assign vrd = gp_ff[vaddr];

   // flag first, then the result; add, sub, subn and the shifts read the new flag in place of vf
   always_comb begin
      sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};
      alu_ok = 1'b1;
      alu_fl = 1'b1;
      unique case (n)
         A_ADD:   flag = sum9[8];
         A_SUB:   flag = (vx_ff > vy_ff);
         A_SHR:   flag = vx_ff[0];
         A_SUBN:  flag = (vy_ff > vx_ff);
         A_SHL:   flag = vx_ff[7];
         default: begin
            flag   = 1'b0;
            alu_fl = 1'b0;
         end
      endcase
      ax = (x == FLAG_REG) ? {7'd0, flag} : vx_ff;
      ay = (y == FLAG_REG) ? {7'd0, flag} : vy_ff;
      unique case (n)
         A_MOV:   alu_res = vy_ff;
         A_OR:    alu_res = vx_ff | vy_ff;
         A_AND:   alu_res = vx_ff & vy_ff;
         A_XOR:   alu_res = vx_ff ^ vy_ff;
         A_ADD:   alu_res = ax + ay;
         A_SUB:   alu_res = ax - ay;
         A_SHR:   alu_res = ax >> 1;
         A_SUBN:  alu_res = ay - ax;
         A_SHL:   alu_res = ax << 1;
         default: begin
            alu_res = vx_ff;
            alu_ok  = 1'b0;
         end
      endcase
   end

   always_comb begin
      hund   = (vx_ff >= DEC_200) ? 2'd2 : ((vx_ff >= DEC_100) ? 2'd1 : 2'd0);
      rem8   = vx_ff - ((hund == 2'd2) ? DEC_200 : ((hund == 2'd1) ? DEC_100 : 8'd0));
      tprod  = rem8[6:0] * RECIP_10;
      tens   = tprod[14:11];
      tens10 = {1'b0, tens, 3'd0} + {3'd0, tens, 1'b0};
      ones   = rem8 - tens10;
      case (cnt_ff)
         ROW_BITS'(0): digit = {6'd0, hund};
         ROW_BITS'(1): digit = {4'd0, tens};
         default:      digit = ones;
      endcase
   end

   always_comb begin
      dmask = '0;
      for (int col = 0; col < 8; col++) begin
         dmask[vx_ff[COL_BITS-1:0] + COL_BITS'(col)] = m_rdata[7-col];
      end
   end

   always_comb begin
      kind = K_SIMPLE;
      if (grp == G_SYS && nn == S_CLS) kind = K_CLS;
      else if (grp == G_SYS && nn == S_RET) kind = K_RET;
      else if (grp == G_DRW) kind = K_DRAW;
      else if (grp == G_MISC && nn == F_BCD) kind = K_BCD;
      else if (grp == G_MISC && nn == F_STR) kind = K_STORE;
      else if (grp == G_MISC && nn == F_LDR) kind = K_LOAD;
   end

   always_comb begin
      stat.init_done = (ic_ff == AW'(MEM_BYTES - 1));
      stat.sel       = sel_type'(sel_ff);
      stat.kind      = kind;
      stat.empty     = (n == 4'd0);
      unique case (kind)
         K_CLS:   stat.last = (cnt_ff == ROW_BITS'(FRAME_ROWS - 1));
         K_DRAW:  stat.last = (cnt_ff == {1'b0, n - 4'd1});
         K_BCD:   stat.last = (cnt_ff == ROW_BITS'(2));
         K_STORE, K_LOAD: stat.last = (cnt_ff == {1'b0, x});
         default: stat.last = 1'b1;
      endcase
   end

   always_comb begin
      sel_in = sel_ff;  ins_in = ins_ff;  addr_in = addr_ff;  wdat_in = wdat_ff;
      keys_in = keys_ff;  pkey_in = pkey_ff;  rnd_in = rnd_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  gp_in = gp_ff;  i_in = i_ff;  pc_in = pc_ff;
      sp_in = sp_ff;  dt_in = dt_ff;  st_in = st_ff;  cnt_in = cnt_ff;  ic_in = ic_ff;
      bad_in = bad_ff;  drew_in = drew_ff;
      rv_in = 1'b0;  rstat_in = rstat_ff;  rdraw_in = rdraw_ff;  rpc_in = rpc_ff;
      rdat_in = rdat_ff;  rsnd_in = rsnd_ff;
      m_we = 1'b0;  m_waddr = '0;  m_wdata = '0;  m_raddr = '0;
      f_we = 1'b0;  f_waddr = '0;  f_wdata = '0;  f_raddr = '0;
      s_we = 1'b0;
      unique case (cmd.uop)
         U_INIT: begin
            m_we    = 1'b1;
            m_waddr = ic_ff;
            m_wdata = (ic_ff < AW'(FONT_BYTES)) ? FONT_ROM[ic_ff[6:0]] : 8'd0;
            f_we    = 1'b1;
            f_waddr = ic_ff[ROW_BITS-1:0];
            if (ic_ff != AW'(MEM_BYTES - 1)) ic_in = ic_ff + AW'(1);
         end
         U_LOAD: begin
            sel_in = req_opcode;  ins_in = req_instruction;  addr_in = req_address;
            wdat_in = req_write_data;  keys_in = req_keys_down;
            pkey_in = req_pressed_key;  rnd_in = req_random_byte;
            bad_in = 1'b0;  drew_in = 1'b0;
         end
         U_RDX: vx_in = vrd;
         U_RDY: vy_in = vrd;
         U_ACC: begin
            m_we    = (sel_ff == SEL_WRITE);
            m_waddr = AW'(addr_ff);
            m_wdata = wdat_ff;
            m_raddr = AW'(addr_ff);
            f_raddr = addr_ff[COL_BITS +: ROW_BITS];
         end
         U_EXEC: begin
            cnt_in = '0;
            pc_in  = pc2;
            unique case (grp)
               G_SYS: begin
                  if (nn == S_CLS) drew_in = 1'b1;
                  else if (nn == S_RET) sp_in = sp_ff - SW'(1);
               end
               G_JP: pc_in = nnn;
               G_CALL: begin
                  s_we  = 1'b1;
                  sp_in = sp_ff + SW'(1);
                  pc_in = nnn;
               end
               G_SE:  if (vx_ff == nn) pc_in = pc4;
               G_SNE: if (vx_ff != nn) pc_in = pc4;
               G_SER: if (vx_ff == vy_ff) pc_in = pc4;
               G_LD:  gp_in[x] = nn;
               G_ADD: gp_in[x] = vx_ff + nn;
               G_ALU: begin
                  if (alu_ok) begin
                     if (alu_fl) gp_in[FLAG_REG] = {7'd0, flag};
                     gp_in[x] = alu_res;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               G_SNER: begin
                  if (n != 4'd0) bad_in = 1'b1;
                  else if (vx_ff != vy_ff) pc_in = pc4;
               end
               G_LDI: i_in = {4'd0, nnn};
               G_JPV: pc_in = {4'd0, vy_ff} + nnn;
               G_RND: gp_in[x] = rnd_ff & nn;
               G_DRW: begin
                  gp_in[FLAG_REG] = 8'd0;
                  drew_in = 1'b1;
               end
               G_KEY: begin
                  if (nn == E_SKP) begin
                     if (held) pc_in = pc4;
                  end else if (nn == E_SKNP) begin
                     if (!held) pc_in = pc4;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               default: begin
                  unique case (nn)
                     F_GDT:  gp_in[x] = dt_ff;
                     F_KEY:  gp_in[x] = {4'd0, pkey_ff};
                     F_SDT:  dt_in = vx_ff;
                     F_SST:  st_in = vx_ff;
                     F_ADDI: i_in = i_ff + {8'd0, vx_ff};
                     F_FONT: i_in = {6'd0, vx_ff, 2'd0} + {8'd0, vx_ff};
                     F_BCD, F_STR, F_LDR: ;
                     default: bad_in = 1'b1;
                  endcase
               end
            endcase
         end
         U_CLR: begin
            f_we    = 1'b1;
            f_waddr = cnt_ff;
            cnt_in  = cnt_ff + ROW_BITS'(1);
         end
         U_RET: pc_in = s_rdata;
         U_DRD: begin
            m_raddr = AW'(i_ff + {11'd0, cnt_ff});
            f_raddr = drow;
         end
         U_DWR: begin
            f_we    = 1'b1;
            f_waddr = drow;
            f_wdata = f_rdata ^ dmask;
            if (hit) gp_in[FLAG_REG] = 8'd1;
            cnt_in  = cnt_ff + ROW_BITS'(1);
         end
         U_BCD: begin
            m_we    = 1'b1;
            m_waddr = AW'(i_ff);
            m_wdata = digit;
            i_in    = i_ff + 16'd1;
            cnt_in  = cnt_ff + ROW_BITS'(1);
         end
         U_STORE: begin
            m_we    = 1'b1;
            m_waddr = AW'(i_ff);
            m_wdata = vrd;
            i_in    = i_ff + 16'd1;
            cnt_in  = cnt_ff + ROW_BITS'(1);
         end
         U_LRD: begin
            m_raddr = AW'(i_ff);
            i_in    = i_ff + 16'd1;
         end
         U_LWR: begin
            gp_in[cnt_ff[3:0]] = m_rdata;
            cnt_in = cnt_ff + ROW_BITS'(1);
         end
         U_DONE: begin
            rv_in    = 1'b1;
            rstat_in = bad_ff;
            rdraw_in = drew_ff;
            rpc_in   = pc_ff;
            rsnd_in  = st_ff;
            case (sel_ff)
               SEL_READ:  rdat_in = m_rdata;
               SEL_PIXEL: rdat_in = {7'd0, f_rdata[addr_ff[COL_BITS-1:0]]};
               default:   rdat_in = 8'd0;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff  <= '{default: '0};
         i_ff   <= '0;
         pc_ff  <= PC_RESET;
         sp_ff  <= '0;
         dt_ff  <= '0;
         st_ff  <= '0;
         ic_ff  <= '0;
         rv_ff  <= 1'b0;
      end else begin
         gp_ff  <= gp_in;
         i_ff   <= i_in;
         pc_ff  <= pc_in;
         sp_ff  <= sp_in;
         dt_ff  <= dt_in;
         st_ff  <= st_in;
         ic_ff  <= ic_in;
         rv_ff  <= rv_in;
      end
      sel_ff <= sel_in;  ins_ff <= ins_in;  addr_ff <= addr_in;  wdat_ff <= wdat_in;
      keys_ff <= keys_in;  pkey_ff <= pkey_in;  rnd_ff <= rnd_in;
      vx_ff <= vx_in;  vy_ff <= vy_in;  cnt_ff <= cnt_in;
      bad_ff <= bad_in;  drew_ff <= drew_in;
      rstat_ff <= rstat_in;  rdraw_ff <= rdraw_in;  rpc_ff <= rpc_in;
      rdat_ff <= rdat_in;  rsnd_ff <= rsnd_in;
   end

   c8x_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
      .raddr(m_raddr), .rdata(m_rdata)
   );

   c8x_ram #(.WIDTH(FRAME_COLS), .DEPTH(FRAME_ROWS)) u_frame (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
      .raddr(f_raddr), .rdata(f_rdata)
   );

   c8x_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .we(s_we), .waddr(sp_ff), .wdata(pc2),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   assign rsp_valid       = rv_ff;
   assign rsp_status      = rstat_ff;
   assign rsp_next_pc     = rpc_ff;
   assign rsp_read_data   = rdat_ff;
   assign rsp_draw_flag   = rdraw_ff;
   assign rsp_sound_level = rsnd_ff;

endmodule

/* sv/chip8_instruction_executor_unit.sv */
// top level of the chip8 instruction executor
//
//   channel   ports                     transfer
//   request   start, busy, req_*        start high while busy low
//   response  rsp_valid, rsp_*          rsp_valid high, one cycle
//
// accesses pass rdx, acc and done, plain instructions rdx, rdy, exec and done;
// clear screen adds a write per frame row, a sprite a read and a write per row,
// bcd and register store a write per digit or register, register load a read
// and a write per register. after reset the block stays busy while it clears
// memory and frame, loads the font. results cannot be held off by the receiver.
// MEM_BYTES and STACK_DEPTH must be powers of two; the block does not check it.
module chip8_instruction_executor_unit import c8x_pkg::*; #(
   parameter int MEM_BYTES   = 4096,
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_instruction,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_keys_down,
   input  logic [3:0]  req_pressed_key,
   input  logic [7:0]  req_random_byte,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [11:0] rsp_next_pc,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_draw_flag,
   output logic [7:0]  rsp_sound_level
);

   cmd_type  cmd;
   stat_type stat;

   c8x_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start),
      .stat(stat), .cmd(cmd), .busy(busy)
   );

   c8x_dp #(.MEM_BYTES(MEM_BYTES), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_opcode(req_opcode), .req_instruction(req_instruction),
      .req_address(req_address), .req_write_data(req_write_data),
      .req_keys_down(req_keys_down), .req_pressed_key(req_pressed_key),
      .req_random_byte(req_random_byte), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_next_pc(rsp_next_pc),
      .rsp_read_data(rsp_read_data), .rsp_draw_flag(rsp_draw_flag),
      .rsp_sound_level(rsp_sound_level)
   );

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   a_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response strobe while still busy");

   a_busy_out_of_reset: assert property (@(posedge clock)
      $past(reset) |-> busy)
      else $error("not busy right after reset");

endmodule
